// ----- sv/leaky_nlms_line_enhancer_defines.svh -----
// assertion macros for the leaky nlms line enhancer checks
// no dependencies; included by the checker file
`ifndef LEAKY_NLMS_LINE_ENHANCER_DEFINES_SVH
`define LEAKY_NLMS_LINE_ENHANCER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LNLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lnle check failed");

// next-cycle implication, disabled while in reset
`define LNLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lnle check failed");

// next-cycle implication that also covers the reset cycles
`define LNLE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lnle check failed");

`endif

// ----- sv/lnle_pkg.sv -----
// shared types and constants of the leaky nlms line enhancer
// no dependencies; used by the design modules by scoped names
package lnle_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int WEIGHT_W  = 24;
  localparam int SFRAC     = 15;
  localparam int WFRAC     = 22;
  localparam int PROD_W    = 40;   // weight times sample
  localparam int MUL_AW    = 34;
  localparam int MUL_BW    = 25;
  localparam int MUL_PW    = 59;
  localparam int POW_W     = 32;
  localparam int NUM_W     = 53;   // step dividend magnitude
  localparam int QSHIFT    = 22;
  localparam int Q_W       = 32;
  localparam int ALPHA_Q24 = 16777;
  localparam int LEAK_Q24  = 16775538;
  localparam int EPS_Q31   = 2147;
  localparam int RATE_MIN  = 66;
  localparam int RATE_MAX  = 32768;
  localparam int TAPS_MIN  = 4;
  localparam int TAPS_RST  = 64;
  localparam int RATE_RST  = 655;
  localparam int SMAX      = 32767;
  localparam int SMIN      = -32768;
  localparam int WMAX      = 8388607;
  localparam int WMIN      = -8388608;

  typedef enum logic [1:0] {
    REG_TAP_COUNT,
    REG_DELAY,
    REG_STEP_RATE,
    REG_OUT_MODE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_PRED,
    ST_PWR_MUL,
    ST_PWR_UPD,
    ST_DEN_MUL,
    ST_NUM_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_UPD_LEAK,
    ST_UPD_STEP,
    ST_UPD_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/lnle_mul.sv -----
// shared signed multiplier with registered product
// depends on lnle_pkg
module lnle_mul (
  input  logic                                   clk,
  input  logic signed [lnle_pkg::MUL_AW-1:0]     a,
  input  logic signed [lnle_pkg::MUL_BW-1:0]     b,
  output logic signed [lnle_pkg::MUL_PW-1:0]     p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ----- sv/lnle_div.sv -----
// unsigned restoring divider, one quotient bit per cycle
// depends on lnle_pkg
module lnle_div #(
  parameter int NW = 53,
  parameter int DW = 42
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [NW-1:0]          num,
  input  logic [DW-1:0]          den,
  output lnle_pkg::div_stat_t    stat,
  output logic [NW-1:0]          quo_r
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [NW-1:0] quo_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   sh;

  always_comb begin
    sh       = {rem_r, quo_r[NW-1]};
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = CW'(NW);
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = DW'(sh - {1'b0, den_r});
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- sv/leaky_nlms_line_enhancer.sv -----
// top level of the leaky nlms adaptive line enhancer: sequencer, memories
// depends on lnle_pkg, lnle_mul, lnle_div
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready   in_tdata  = sample (16b signed q1.15)
//  out_     out  out_tvalid/out_tready out_tdata = result (16b signed q1.15)
//  cfg_     in   cfg_valid/cfg_ready   cfg_index (register), cfg_data (value)
//
// one sample makes two passes over the taps through the single shared
// multiplier (states MAC_MUL and MAC_ACC per tap for the prediction, UPD_LEAK,
// UPD_STEP and UPD_WRITE per tap for the weight update) plus a 53-bit
// bit-serial divide for the normalized step; after reset, and after every write
// of tap_count or delay_samples, a clearing pass zeroes the memories;
// in_tready stays low during it, config beats are still taken
// a finished result sits in the output register; if it is still stalled when
// the next result is ready, the block waits before taking another sample
module leaky_nlms_line_enhancer #(
  parameter int MAX_TAPS  = 256,
  parameter int MAX_DELAY = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TW   = $clog2(MAX_TAPS + 1);
  localparam int DLW  = $clog2(MAX_DELAY + 1);
  localparam int HD   = MAX_TAPS + MAX_DELAY + 1;
  localparam int HAW  = $clog2(HD);
  localparam int SZW  = $clog2(HD + 1);
  localparam int WAW  = $clog2(MAX_TAPS);
  localparam int ACCW = lnle_pkg::PROD_W + TW;
  localparam int DENW = lnle_pkg::POW_W + TW + 1;
  localparam int SW   = lnle_pkg::SAMPLE_W;
  localparam int WW   = lnle_pkg::WEIGHT_W;
  localparam int PW   = lnle_pkg::MUL_PW;

  // state and registers
  lnle_pkg::state_t state_r, state_nxt;

  logic [TW-1:0]      taps_r, taps_nxt;
  logic [DLW-1:0]     delay_r, delay_nxt;
  logic [15:0]        rate_r, rate_nxt;
  logic               mode_r, mode_nxt;
  logic               cfg_clear;

  logic [HAW-1:0]     clr_r, clr_nxt;
  logic [SZW-1:0]     wp_r, wp_nxt;
  logic [lnle_pkg::POW_W-1:0] pow_r, pow_nxt;
  logic signed [SW-1:0]       s_r, s_nxt;
  logic signed [ACCW-1:0]     acc_r, acc_nxt;
  logic signed [SW-1:0]       ypred_r, ypred_nxt;
  logic signed [SW:0]         err_r, err_nxt;
  logic [DENW-1:0]            den_r, den_nxt;
  logic                       neg_r, neg_nxt;
  logic signed [lnle_pkg::Q_W-1:0] q_r, q_nxt;
  logic signed [WW:0]         r1_r, r1_nxt;
  logic [WAW-1:0]             j_r, j_nxt;
  logic [HAW-1:0]             idx_r, idx_nxt;
  logic [HAW-1:0]             start_r, start_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SW-1:0]              out_data_r, out_data_nxt;

  // memories
  logic signed [SW-1:0] hist_mem [HD];
  logic signed [WW-1:0] wgt_mem  [MAX_TAPS];
  logic signed [SW-1:0] h_rd_r;
  logic signed [WW-1:0] w_rd_r;
  logic                 h_we, w_we;
  logic [HAW-1:0]       h_wa;
  logic [WAW-1:0]       w_wa;
  logic signed [SW-1:0] h_wd;
  logic signed [WW-1:0] w_wd;

  // shared units
  logic signed [lnle_pkg::MUL_AW-1:0] mul_a;
  logic signed [lnle_pkg::MUL_BW-1:0] mul_b;
  logic signed [PW-1:0]               mul_p;
  logic                               div_start;
  logic [lnle_pkg::NUM_W-1:0]         div_num;
  lnle_pkg::div_stat_t                div_stat;
  logic [lnle_pkg::NUM_W-1:0]         div_quo;

  // helpers
  logic               in_beat;
  logic               last_tap;
  logic [SZW-1:0]     size;
  logic [SZW-1:0]     wpc, wpn, back;
  logic [SZW:0]       start_full;
  logic signed [ACCW-1:0] acc_rnd;
  logic signed [SW-1:0]   ypred_sat;
  logic signed [SW-1:0]   err_sat;
  logic [lnle_pkg::POW_W-1:0] x2;
  logic signed [PW-1:0]   prnd, psum;
  logic signed [32:0]     num_s;
  logic [32:0]            num_mag;
  logic signed [PW-1:0]   r2;
  logic signed [WW+9:0]   wsum;
  logic [HAW-1:0]         idx_dec;

  lnle_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  lnle_div #(
    .NW (lnle_pkg::NUM_W),
    .DW (DENW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .stat  (div_stat),
    .quo_r (div_quo)
  );

  assign in_tready  = (state_r == lnle_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_beat    = in_tvalid && in_tready;

  // geometry of the circular history
  assign size     = SZW'(taps_r) + SZW'(delay_r) + SZW'(1);
  assign wpc      = (wp_r >= size) ? '0 : wp_r;
  assign wpn      = (wpc + SZW'(1) == size) ? '0 : wpc + SZW'(1);
  assign back     = SZW'(delay_r) + SZW'(1);
  assign start_full = (wpn >= back) ? {1'b0, wpn} - {1'b0, back}
                                    : {1'b0, wpn} + {1'b0, size} - {1'b0, back};
  assign idx_dec  = (idx_r == '0) ? HAW'(size - SZW'(1)) : idx_r - HAW'(1);
  assign last_tap = ({{(TW-WAW){1'b0}}, j_r} == taps_r - TW'(1));

  // prediction rounding and saturation
  always_comb begin
    acc_rnd = (acc_r + (ACCW'(1) <<< (lnle_pkg::WFRAC - 1))) >>> lnle_pkg::WFRAC;
    if (acc_rnd > ACCW'(lnle_pkg::SMAX))
      ypred_sat = SW'(lnle_pkg::SMAX);
    else if (acc_rnd < ACCW'(lnle_pkg::SMIN))
      ypred_sat = SW'(lnle_pkg::SMIN);
    else
      ypred_sat = acc_rnd[SW-1:0];
    if (err_r > (SW+1)'(lnle_pkg::SMAX))
      err_sat = SW'(lnle_pkg::SMAX);
    else if (err_r < (SW+1)'(lnle_pkg::SMIN))
      err_sat = SW'(lnle_pkg::SMIN);
    else
      err_sat = err_r[SW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lnle_pkg::ST_CLEAR:
        if (clr_r == HAW'(HD - 1)) state_nxt = lnle_pkg::ST_IDLE;
      lnle_pkg::ST_IDLE:
        if (in_beat) state_nxt = lnle_pkg::ST_MAC_MUL;
      lnle_pkg::ST_MAC_MUL:   state_nxt = lnle_pkg::ST_MAC_ACC;
      lnle_pkg::ST_MAC_ACC:
        state_nxt = last_tap ? lnle_pkg::ST_PRED : lnle_pkg::ST_MAC_MUL;
      lnle_pkg::ST_PRED:      state_nxt = lnle_pkg::ST_PWR_MUL;
      lnle_pkg::ST_PWR_MUL:   state_nxt = lnle_pkg::ST_PWR_UPD;
      lnle_pkg::ST_PWR_UPD:   state_nxt = lnle_pkg::ST_DEN_MUL;
      lnle_pkg::ST_DEN_MUL:   state_nxt = lnle_pkg::ST_NUM_MUL;
      lnle_pkg::ST_NUM_MUL:   state_nxt = lnle_pkg::ST_DIV_START;
      lnle_pkg::ST_DIV_START: state_nxt = lnle_pkg::ST_DIV_WAIT;
      lnle_pkg::ST_DIV_WAIT:
        if (div_stat.done) state_nxt = lnle_pkg::ST_UPD_LEAK;
      lnle_pkg::ST_UPD_LEAK:  state_nxt = lnle_pkg::ST_UPD_STEP;
      lnle_pkg::ST_UPD_STEP:  state_nxt = lnle_pkg::ST_UPD_WRITE;
      lnle_pkg::ST_UPD_WRITE:
        state_nxt = last_tap ? lnle_pkg::ST_DONE : lnle_pkg::ST_UPD_LEAK;
      lnle_pkg::ST_DONE:
        if (!out_valid_r || out_tready) state_nxt = lnle_pkg::ST_IDLE;
      default: state_nxt = lnle_pkg::ST_CLEAR;
    endcase
    if (cfg_clear) state_nxt = lnle_pkg::ST_CLEAR;
  end

  // config register writes, values clamped into range
  always_comb begin
    taps_nxt  = taps_r;
    delay_nxt = delay_r;
    rate_nxt  = rate_r;
    mode_nxt  = mode_r;
    cfg_clear = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        lnle_pkg::REG_TAP_COUNT: begin
          if (cfg_data < 16'(lnle_pkg::TAPS_MIN))  taps_nxt = TW'(lnle_pkg::TAPS_MIN);
          else if (cfg_data > 16'(MAX_TAPS))       taps_nxt = TW'(MAX_TAPS);
          else                                     taps_nxt = cfg_data[TW-1:0];
          cfg_clear = 1'b1;
        end
        lnle_pkg::REG_DELAY: begin
          if (cfg_data < 16'd1)                    delay_nxt = DLW'(1);
          else if (cfg_data > 16'(MAX_DELAY))      delay_nxt = DLW'(MAX_DELAY);
          else                                     delay_nxt = cfg_data[DLW-1:0];
          cfg_clear = 1'b1;
        end
        lnle_pkg::REG_STEP_RATE: begin
          if (cfg_data < 16'(lnle_pkg::RATE_MIN))  rate_nxt = 16'(lnle_pkg::RATE_MIN);
          else if (cfg_data > 16'(lnle_pkg::RATE_MAX)) rate_nxt = 16'(lnle_pkg::RATE_MAX);
          else                                     rate_nxt = cfg_data;
        end
        lnle_pkg::REG_OUT_MODE: mode_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  // datapath and memory control
  always_comb begin
    clr_nxt       = clr_r;
    wp_nxt        = wp_r;
    pow_nxt       = pow_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    ypred_nxt     = ypred_r;
    err_nxt       = err_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    q_nxt         = q_r;
    r1_nxt        = r1_r;
    j_nxt         = j_r;
    idx_nxt       = idx_r;
    start_nxt     = start_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    h_we          = 1'b0;
    h_wa          = clr_r;
    h_wd          = '0;
    w_we          = 1'b0;
    w_wa          = j_r;
    w_wd          = '0;
    x2            = {mul_p[30:0], 1'b0};
    prnd          = (mul_p + (PW'(1) <<< 23)) >>> 24;
    psum          = PW'(pow_r) + prnd;
    num_s         = mul_p[32:0];
    num_mag       = num_s[32] ? 33'(-num_s) : num_s;
    div_num       = {num_mag[30:0], {lnle_pkg::QSHIFT{1'b0}}};
    r2            = (mul_p + (PW'(1) <<< (lnle_pkg::SFRAC - 1))) >>> lnle_pkg::SFRAC;
    wsum          = (WW+10)'(r1_r) + (WW+10)'(r2);

    case (state_r)
      lnle_pkg::ST_CLEAR: begin
        h_we    = 1'b1;
        w_we    = (clr_r < HAW'(MAX_TAPS));
        w_wa    = clr_r[WAW-1:0];
        clr_nxt = clr_r + HAW'(1);
      end
      lnle_pkg::ST_IDLE: begin
        if (in_beat) begin
          s_nxt     = in_tdata;
          h_we      = 1'b1;
          h_wa      = wpc[HAW-1:0];
          h_wd      = in_tdata;
          wp_nxt    = wpn;
          start_nxt = start_full[HAW-1:0];
          idx_nxt   = start_full[HAW-1:0];
          j_nxt     = '0;
          acc_nxt   = '0;
        end
      end
      lnle_pkg::ST_MAC_MUL: begin
        mul_a = lnle_pkg::MUL_AW'(w_rd_r);
        mul_b = lnle_pkg::MUL_BW'(h_rd_r);
      end
      lnle_pkg::ST_MAC_ACC: begin
        acc_nxt = acc_r + ACCW'($signed(mul_p[lnle_pkg::PROD_W-1:0]));
        j_nxt   = j_r + WAW'(1);
        idx_nxt = idx_dec;
      end
      lnle_pkg::ST_PRED: begin
        ypred_nxt = ypred_sat;
        err_nxt   = (SW+1)'(s_r) - (SW+1)'(ypred_sat);
        mul_a     = lnle_pkg::MUL_AW'(s_r);
        mul_b     = lnle_pkg::MUL_BW'(s_r);
      end
      lnle_pkg::ST_PWR_MUL: begin
        // alpha times the difference between sample power and the estimate
        mul_a = $signed({2'b00, x2}) - $signed({2'b00, pow_r});
        mul_b = lnle_pkg::MUL_BW'(lnle_pkg::ALPHA_Q24);
      end
      lnle_pkg::ST_PWR_UPD: begin
        if (psum < 0)
          pow_nxt = '0;
        else if (psum > PW'({lnle_pkg::POW_W{1'b1}}))
          pow_nxt = '1;
        else
          pow_nxt = psum[lnle_pkg::POW_W-1:0];
      end
      lnle_pkg::ST_DEN_MUL: begin
        mul_a = $signed({2'b00, pow_r});
        mul_b = $signed({{(lnle_pkg::MUL_BW-TW){1'b0}}, taps_r});
      end
      lnle_pkg::ST_NUM_MUL: begin
        den_nxt = mul_p[DENW-1:0] + DENW'(lnle_pkg::EPS_Q31);
        mul_a   = lnle_pkg::MUL_AW'(err_r);
        mul_b   = $signed({{(lnle_pkg::MUL_BW-16){1'b0}}, rate_r});
      end
      lnle_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        neg_nxt   = num_s[32];
      end
      lnle_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          // truncated quotient, saturated to the 32-bit step range
          if (!neg_r) begin
            if (div_quo > lnle_pkg::NUM_W'(32'h7fff_ffff)) q_nxt = 32'sh7fff_ffff;
            else                                           q_nxt = div_quo[31:0];
          end else begin
            if (div_quo > lnle_pkg::NUM_W'(33'h0_8000_0000)) q_nxt = 32'sh8000_0000;
            else                                    q_nxt = 32'(-div_quo[32:0]);
          end
          j_nxt   = '0;
          idx_nxt = start_r;
        end
      end
      lnle_pkg::ST_UPD_LEAK: begin
        mul_a = lnle_pkg::MUL_AW'(w_rd_r);
        mul_b = lnle_pkg::MUL_BW'(lnle_pkg::LEAK_Q24);
      end
      lnle_pkg::ST_UPD_STEP: begin
        r1_nxt = prnd[WW:0];
        mul_a  = lnle_pkg::MUL_AW'(q_r);
        mul_b  = lnle_pkg::MUL_BW'(h_rd_r);
      end
      lnle_pkg::ST_UPD_WRITE: begin
        w_we = 1'b1;
        if (wsum > (WW+10)'(lnle_pkg::WMAX))
          w_wd = WW'(lnle_pkg::WMAX);
        else if (wsum < (WW+10)'(lnle_pkg::WMIN))
          w_wd = WW'(lnle_pkg::WMIN);
        else
          w_wd = wsum[WW-1:0];
        j_nxt   = j_r + WAW'(1);
        idx_nxt = idx_dec;
      end
      lnle_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mode_r ? ypred_r : err_sat;
        end
      end
      default: ;
    endcase

    if (cfg_clear) begin
      clr_nxt = '0;
      wp_nxt  = '0;
      pow_nxt = lnle_pkg::POW_W'(lnle_pkg::EPS_Q31);
    end
  end

  // memories, read data registered from the next address
  always_ff @(posedge clk) begin
    if (h_we) hist_mem[h_wa] <= h_wd;
    h_rd_r <= hist_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (w_we) wgt_mem[w_wa] <= w_wd;
    w_rd_r <= wgt_mem[j_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lnle_pkg::ST_CLEAR;
      taps_r      <= TW'(lnle_pkg::TAPS_RST);
      delay_r     <= DLW'(1);
      rate_r      <= 16'(lnle_pkg::RATE_RST);
      mode_r      <= 1'b0;
      clr_r       <= '0;
      wp_r        <= '0;
      pow_r       <= lnle_pkg::POW_W'(lnle_pkg::EPS_Q31);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      taps_r      <= taps_nxt;
      delay_r     <= delay_nxt;
      rate_r      <= rate_nxt;
      mode_r      <= mode_nxt;
      clr_r       <= clr_nxt;
      wp_r        <= wp_nxt;
      pow_r       <= pow_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s_r        <= s_nxt;
    acc_r      <= acc_nxt;
    ypred_r    <= ypred_nxt;
    err_r      <= err_nxt;
    den_r      <= den_nxt;
    neg_r      <= neg_nxt;
    q_r        <= q_nxt;
    r1_r       <= r1_nxt;
    j_r        <= j_nxt;
    idx_r      <= idx_nxt;
    start_r    <= start_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- sv/lnle_checker.sv -----
// port-level checks of the line enhancer, bound to the top level
// depends on leaky_nlms_line_enhancer_defines.svh
`include "leaky_nlms_line_enhancer_defines.svh"

module lnle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result beat holds
  `LNLE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // one sample at a time: busy right after an input beat
  `LNLE_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready)
  // reset starts the clearing pass with no result pending
  `LNLE_ASSERT_RST(a_reset_clear, !rst_n, !in_tready && !out_tvalid)
  // a result cannot appear in the cycle after an input beat
  `LNLE_ASSERT_NEXT(a_no_instant_out, in_tvalid && in_tready && !out_tvalid, !out_tvalid)

endmodule

bind leaky_nlms_line_enhancer lnle_checker u_lnle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
